// ===== src/uwlcc_pkg.sv =====
// shared types, constants and codes of the utf-8 word, line and character counter
package uwlcc_pkg;

   // widths of the ports and of the stored state
   localparam int COUNT_WIDTH_DEFAULT = 48;
   localparam int TOTAL_WIDTH         = 48;
   localparam int TOTAL_COUNT         = 4;
   localparam int RSP_WIDTH           = TOTAL_COUNT * TOTAL_WIDTH;
   localparam int BYTE_WIDTH          = 8;
   localparam int STATE_WIDTH         = 7;
   localparam int MASK_WIDTH          = 20;
   localparam int CSR_ADDR_WIDTH      = 1;
   localparam int CSR_DATA_WIDTH      = 20;
   localparam int STATE_DEPTH         = 2;
   localparam int STATE_ADDR_WIDTH    = 1;

   // opcodes carried in tuser
   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_UTF8_MODE  = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_SPACE_MASK = 1'd1;

   localparam logic                  UTF8_MODE_RESET = 1'b0;
   localparam logic [MASK_WIDTH-1:0] MASK_RESET      = 20'd900092;

   // scanner state codes
   localparam logic [STATE_WIDTH-1:0] ST_SPACE    = 7'd0;
   localparam logic [STATE_WIDTH-1:0] ST_NEWLINE  = 7'd1;
   localparam logic [STATE_WIDTH-1:0] ST_NEWWORD  = 7'd2;
   localparam logic [STATE_WIDTH-1:0] ST_INWORD   = 7'd3;
   localparam logic [STATE_WIDTH-1:0] BASE_SPACE  = 7'd4;
   localparam logic [STATE_WIDTH-1:0] BASE_WORD   = 7'd23;
   localparam logic [STATE_WIDTH-1:0] STATE_LIMIT = 7'd42;

   // pending utf-8 sequence kinds
   typedef enum logic [4:0] {
      S_DUO_C2, S_DUO_X, S_TRI_E0, S_TRI_E1, S_TRI_E2, S_TRI_E3, S_TRI_ED,
      S_TRI_X, S_T3_E1_9A, S_T3_E2_80, S_T3_E2_81, S_T3_E3_80, S_T3_X,
      S_Q2_F0, S_Q2_X, S_Q2_F4, S_Q3, S_Q4, S_BAD
   } sub_type;

   // result of one scanner step
   typedef struct packed {
      logic [STATE_WIDTH-1:0] next_state;
      logic                   count_char;
      logic                   count_line;
      logic                   count_word;
   } step_type;

endpackage

// ===== src/uwlcc_ram.sv =====
// generic single-write, single-read ram with registered read data
module uwlcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/uwlcc_step.sv =====
// scanner transition: next state and count flags for one data byte
module uwlcc_step (
   input  logic [uwlcc_pkg::STATE_WIDTH-1:0] cur_state,
   input  logic [uwlcc_pkg::BYTE_WIDTH-1:0]  data_byte,
   input  logic                              utf8_mode,
   input  logic [uwlcc_pkg::MASK_WIDTH-1:0]  space_mask,
   output uwlcc_pkg::step_type               step
);

   logic                              ctx;
   logic                              pending;
   logic [uwlcc_pkg::STATE_WIDTH-1:0] base;
   logic [uwlcc_pkg::STATE_WIDTH-1:0] done_state;
   logic [uwlcc_pkg::STATE_WIDTH-1:0] sub_raw;
   uwlcc_pkg::sub_type                sub;
   logic                              is_space;
   logic [uwlcc_pkg::STATE_WIDTH-1:0] lead_state;
   logic [uwlcc_pkg::STATE_WIDTH-1:0] cont_state;
   logic [uwlcc_pkg::STATE_WIDTH-1:0] nxt;
   logic [4:0]                        gen_idx;

   function automatic logic [uwlcc_pkg::STATE_WIDTH-1:0] sub_code(
      input logic [uwlcc_pkg::STATE_WIDTH-1:0] b_base,
      input uwlcc_pkg::sub_type                s
   );
      return uwlcc_pkg::STATE_WIDTH'(b_base + {2'b00, s});
   endfunction

   // decode context and pending sequence
   always_comb begin
      ctx = (cur_state == uwlcc_pkg::ST_NEWWORD) || (cur_state == uwlcc_pkg::ST_INWORD) ||
            (cur_state >= uwlcc_pkg::BASE_WORD && cur_state < uwlcc_pkg::STATE_LIMIT);
      pending = (cur_state >= uwlcc_pkg::BASE_SPACE) && (cur_state < uwlcc_pkg::STATE_LIMIT);
      base = ctx ? uwlcc_pkg::BASE_WORD : uwlcc_pkg::BASE_SPACE;
      done_state = ctx ? uwlcc_pkg::ST_INWORD : uwlcc_pkg::ST_NEWWORD;
      sub_raw = cur_state - base;
      sub = uwlcc_pkg::sub_type'(sub_raw[4:0]);
      is_space = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
      gen_idx = 5'(data_byte[3:0]) + 5'd3;
   end

   // byte with no sequence pending
   always_comb begin
      if (data_byte == 8'h0A) begin
         lead_state = uwlcc_pkg::ST_NEWLINE;
      end else if (is_space) begin
         lead_state = uwlcc_pkg::ST_SPACE;
      end else if (data_byte < 8'h80) begin
         lead_state = done_state;
      end else if (data_byte == 8'hC2) begin
         lead_state = sub_code(base, uwlcc_pkg::S_DUO_C2);
      end else if (data_byte > 8'hC2 && data_byte <= 8'hDF) begin
         lead_state = sub_code(base, uwlcc_pkg::S_DUO_X);
      end else if (data_byte == 8'hE0) begin
         lead_state = sub_code(base, uwlcc_pkg::S_TRI_E0);
      end else if (data_byte == 8'hE1) begin
         lead_state = sub_code(base, uwlcc_pkg::S_TRI_E1);
      end else if (data_byte == 8'hE2) begin
         lead_state = sub_code(base, uwlcc_pkg::S_TRI_E2);
      end else if (data_byte == 8'hE3) begin
         lead_state = sub_code(base, uwlcc_pkg::S_TRI_E3);
      end else if (data_byte == 8'hED) begin
         lead_state = sub_code(base, uwlcc_pkg::S_TRI_ED);
      end else if (data_byte == 8'hF0) begin
         lead_state = sub_code(base, uwlcc_pkg::S_Q2_F0);
      end else if (data_byte == 8'hF4) begin
         lead_state = sub_code(base, uwlcc_pkg::S_Q2_F4);
      end else if (data_byte >= 8'hE4 && data_byte <= 8'hEF) begin
         lead_state = sub_code(base, uwlcc_pkg::S_TRI_X);
      end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
         lead_state = sub_code(base, uwlcc_pkg::S_Q2_X);
      end else begin
         lead_state = sub_code(base, uwlcc_pkg::S_BAD);
      end
   end

   // continuation byte while a sequence is pending
   always_comb begin
      case (sub)
         uwlcc_pkg::S_DUO_C2: begin
            if ((data_byte == 8'h85 && space_mask[0]) || (data_byte == 8'hA0 && space_mask[1]))
               cont_state = uwlcc_pkg::ST_SPACE;
            else
               cont_state = done_state;
         end
         uwlcc_pkg::S_DUO_X: cont_state = done_state;
         uwlcc_pkg::S_TRI_E0: cont_state = (data_byte < 8'hA0) ?
            sub_code(base, uwlcc_pkg::S_BAD) : sub_code(base, uwlcc_pkg::S_T3_X);
         uwlcc_pkg::S_TRI_E1: cont_state = (data_byte == 8'h9A) ?
            sub_code(base, uwlcc_pkg::S_T3_E1_9A) : sub_code(base, uwlcc_pkg::S_T3_X);
         uwlcc_pkg::S_TRI_E2: begin
            if (data_byte == 8'h80)
               cont_state = sub_code(base, uwlcc_pkg::S_T3_E2_80);
            else if (data_byte == 8'h81)
               cont_state = sub_code(base, uwlcc_pkg::S_T3_E2_81);
            else
               cont_state = sub_code(base, uwlcc_pkg::S_T3_X);
         end
         uwlcc_pkg::S_TRI_E3: cont_state = (data_byte == 8'h80) ?
            sub_code(base, uwlcc_pkg::S_T3_E3_80) : sub_code(base, uwlcc_pkg::S_T3_X);
         uwlcc_pkg::S_TRI_ED: cont_state = (data_byte >= 8'hA0) ?
            sub_code(base, uwlcc_pkg::S_BAD) : sub_code(base, uwlcc_pkg::S_T3_X);
         uwlcc_pkg::S_TRI_X: cont_state = sub_code(base, uwlcc_pkg::S_T3_X);
         uwlcc_pkg::S_T3_E1_9A: cont_state = (data_byte == 8'h80 && space_mask[2]) ?
            uwlcc_pkg::ST_SPACE : done_state;
         uwlcc_pkg::S_T3_E2_80: begin
            // general punctuation spaces and separators
            if (data_byte <= 8'h8B && space_mask[gen_idx])
               cont_state = uwlcc_pkg::ST_SPACE;
            else if ((data_byte == 8'hA8 && space_mask[15]) ||
                     (data_byte == 8'hA9 && space_mask[16]) ||
                     (data_byte == 8'hAF && space_mask[17]))
               cont_state = uwlcc_pkg::ST_SPACE;
            else
               cont_state = done_state;
         end
         uwlcc_pkg::S_T3_E2_81: cont_state = (data_byte == 8'h9F && space_mask[18]) ?
            uwlcc_pkg::ST_SPACE : done_state;
         uwlcc_pkg::S_T3_E3_80: cont_state = (data_byte == 8'h80 && space_mask[19]) ?
            uwlcc_pkg::ST_SPACE : done_state;
         uwlcc_pkg::S_T3_X: cont_state = done_state;
         uwlcc_pkg::S_Q2_F0: cont_state = (data_byte < 8'h90) ?
            sub_code(base, uwlcc_pkg::S_BAD) : sub_code(base, uwlcc_pkg::S_Q3);
         uwlcc_pkg::S_Q2_F4: cont_state = (data_byte >= 8'h90) ?
            sub_code(base, uwlcc_pkg::S_BAD) : sub_code(base, uwlcc_pkg::S_Q3);
         uwlcc_pkg::S_Q2_X: cont_state = sub_code(base, uwlcc_pkg::S_Q3);
         uwlcc_pkg::S_Q3: cont_state = sub_code(base, uwlcc_pkg::S_Q4);
         uwlcc_pkg::S_Q4: cont_state = done_state;
         default: cont_state = sub_code(base, uwlcc_pkg::S_BAD);
      endcase
   end

   // mode select and count flags
   always_comb begin
      if (!utf8_mode) begin
         if (data_byte == 8'h0A)
            nxt = uwlcc_pkg::ST_NEWLINE;
         else if (is_space)
            nxt = uwlcc_pkg::ST_SPACE;
         else
            nxt = done_state;
      end else if (!pending || data_byte < 8'h80 || data_byte >= 8'hC0) begin
         nxt = lead_state;
      end else begin
         nxt = cont_state;
      end
      step.next_state = nxt;
      step.count_char = (nxt < uwlcc_pkg::BASE_SPACE);
      step.count_line = (nxt == uwlcc_pkg::ST_NEWLINE);
      step.count_word = (nxt == uwlcc_pkg::ST_NEWWORD);
   end

endmodule

// ===== src/utf8_word_line_char_counter_unit.sv =====
// top level of the utf-8 word, line, character and byte counter
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata data_byte, tuser opcode
//   rsp      out  rsp_tvalid/rsp_tready  tdata line, word, char, byte totals
//   csr      in   csr_we                 csr_addr, csr_wdata
//
// one beat per cycle while req_tready is high: the scanner state and counters sit in
// one ram word that is read every cycle and written on every accepted beat, the last
// write forwarded. a report returns its totals in the cycle after acceptance, from the
// output register. after reset one cycle writes zeros to the ram word; req_tready is
// low meanwhile. data beats are taken while a report waits; a report stalls only in
// the clearing cycle or while the output register is full and rsp_tready is low.
module utf8_word_line_char_counter_unit #(
   parameter int COUNT_WIDTH = uwlcc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // data_byte [7:0]
   input  logic [uwlcc_pkg::BYTE_WIDTH-1:0]     req_tdata,
   // opcode [0]
   input  logic [0:0]                           req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // line_total [47:0], word_total [95:48], char_total [143:96], byte_total [191:144]
   output logic [uwlcc_pkg::RSP_WIDTH-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [uwlcc_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [uwlcc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int SW = uwlcc_pkg::STATE_WIDTH;
   localparam int TW = uwlcc_pkg::TOTAL_WIDTH;
   localparam int NC = uwlcc_pkg::TOTAL_COUNT;
   localparam int MEM_WIDTH = SW + NC * COUNT_WIDTH;

   // configuration registers
   logic                                 utf8_mode_ff;
   logic [uwlcc_pkg::MASK_WIDTH-1:0]     space_mask_ff;

   // ram access and forwarding
   logic [uwlcc_pkg::STATE_ADDR_WIDTH-1:0] state_addr;
   logic                                 wr_en;
   logic [MEM_WIDTH-1:0]                 wr_data;
   logic [MEM_WIDTH-1:0]                 rd_data;
   logic                                 fwd_valid_ff;
   logic [MEM_WIDTH-1:0]                 fwd_data_ff;
   logic [MEM_WIDTH-1:0]                 cur_word;
   logic                                 clear_ff;

   // current and next state
   logic [SW-1:0]                        cur_state;
   logic [COUNT_WIDTH-1:0]               cur_cnt [NC];
   logic [COUNT_WIDTH-1:0]               nxt_cnt [NC];
   logic [NC-1:0]                        cnt_en;
   logic [TW-1:0]                        cur_total [NC];
   uwlcc_pkg::step_type                  step;

   // handshake and output register
   logic                                 req_acc;
   logic                                 rpt_acc;
   logic                                 data_acc;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [uwlcc_pkg::RSP_WIDTH-1:0]      rsp_data_ff;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(
      input logic [COUNT_WIDTH-1:0] c,
      input logic                   en
   );
      return (en && (c != {COUNT_WIDTH{1'b1}})) ? c + 1'b1 : c;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_mode_ff  <= uwlcc_pkg::UTF8_MODE_RESET;
         space_mask_ff <= uwlcc_pkg::MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            uwlcc_pkg::REG_UTF8_MODE:  utf8_mode_ff  <= csr_wdata[0];
            uwlcc_pkg::REG_SPACE_MASK: space_mask_ff <= csr_wdata[uwlcc_pkg::MASK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_tready = !clear_ff &&
                       ((req_tuser[0] == uwlcc_pkg::OP_DATA) || !rsp_valid_ff || rsp_tready);
   assign req_acc  = req_tvalid && req_tready;
   assign rpt_acc  = req_acc && (req_tuser[0] == uwlcc_pkg::OP_REPORT);
   assign data_acc = req_acc && (req_tuser[0] == uwlcc_pkg::OP_DATA);

   // state ram: one word, read every cycle
   assign state_addr = '0;

   uwlcc_ram #(
      .WIDTH (MEM_WIDTH),
      .DEPTH (uwlcc_pkg::STATE_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (state_addr),
      .wr_data (wr_data),
      .rd_addr (state_addr),
      .rd_data (rd_data)
   );

   // the ram returns the word from before the last write, so forward that write
   assign cur_word  = fwd_valid_ff ? fwd_data_ff : rd_data;
   assign cur_state = cur_word[SW-1:0];

   // unpack counters: line, word, char, byte
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         cur_cnt[i] = cur_word[SW + i*COUNT_WIDTH +: COUNT_WIDTH];
      end
   end

   uwlcc_step u_step (
      .cur_state  (cur_state),
      .data_byte  (req_tdata),
      .utf8_mode  (utf8_mode_ff),
      .space_mask (space_mask_ff),
      .step       (step)
   );

   // counter update
   always_comb begin
      cnt_en = {1'b1, step.count_char, step.count_word, step.count_line};
      for (int i = 0; i < NC; i++) begin
         nxt_cnt[i] = sat_inc(cur_cnt[i], cnt_en[i]);
      end
   end

   // write-back: zeros on clear or report, updated word on a data beat
   always_comb begin
      wr_en   = clear_ff || req_acc;
      wr_data = '0;
      if (data_acc) begin
         wr_data[SW-1:0] = step.next_state;
         for (int i = 0; i < NC; i++) begin
            wr_data[SW + i*COUNT_WIDTH +: COUNT_WIDTH] = nxt_cnt[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         fwd_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= 1'b0;
         fwd_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   // totals at the output width
   generate
      for (genvar g = 0; g < NC; g++) begin : g_total
         if (COUNT_WIDTH >= TW) begin : g_trunc
            assign cur_total[g] = cur_cnt[g][TW-1:0];
         end else begin : g_ext
            assign cur_total[g] = {{(TW-COUNT_WIDTH){1'b0}}, cur_cnt[g]};
         end
      end
   endgenerate

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rpt_acc)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rpt_acc) begin
         rsp_data_ff <= {cur_total[3], cur_total[2], cur_total[1], cur_total[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/uwlcc_checker.sv =====
// port-level checks of the counter unit and their binding
module uwlcc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic [0:0]                           req_tuser,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [uwlcc_pkg::RSP_WIDTH-1:0]      rsp_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   logic rpt_beat;

   assign rpt_beat = req_tvalid && req_tready && (req_tuser[0] == uwlcc_pkg::OP_REPORT);

   // the ram clearing cycle after reset takes no beat
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("input ready during clearing cycle");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // every report yields a result in the next cycle
   a_report_result: assert property (@(posedge clock) disable iff (reset)
      rpt_beat |=> rsp_tvalid)
      else $error("report without result");

   // a result appears only after a report
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(rpt_beat))
      else $error("result without report");

   // two reports in a row: the second sees cleared totals
   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      rpt_beat ##1 rpt_beat |=> rsp_tdata == '0)
      else $error("totals not cleared by report");

endmodule

bind utf8_word_line_char_counter_unit uwlcc_checker u_uwlcc_checker (.*);

// ===== dv/tb_utf8_word_line_char_counter_unit.sv =====
// testbench for the utf-8 word, line, character and byte counter
`timescale 1ns / 1ps

module tb_utf8_word_line_char_counter_unit;
   import uwlcc_pkg::*;

   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int CNT_W         = COUNT_WIDTH_DEFAULT;
   localparam int MAX_WAIT      = 17;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int ITEM_TARGET   = 450;
   localparam int REPORT_TARGET = 20;
   localparam int SHOWN_MISSES  = 10;

   // what the driver does with one queue entry
   typedef enum logic [1:0] {ACT_BEAT, ACT_CSR, ACT_DRAIN, ACT_HOLD} act_type;

   typedef struct {
      act_type                   kind;
      logic                      op;
      logic [BYTE_WIDTH-1:0]     data;
      logic [CSR_ADDR_WIDTH-1:0] addr;
      logic [CSR_DATA_WIDTH-1:0] wdata;
   } stim_type;

   // same layout as rsp_tdata, line total in the low bits
   typedef struct packed {
      logic [TOTAL_WIDTH-1:0] byte_total;
      logic [TOTAL_WIDTH-1:0] char_total;
      logic [TOTAL_WIDTH-1:0] word_total;
      logic [TOTAL_WIDTH-1:0] line_total;
   } totals_type;

   // how one byte leaves the scanner
   typedef enum logic [1:0] {GO_NEWLINE, GO_BLANK, GO_GLYPH, GO_OPEN} scan_go_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic [BYTE_WIDTH-1:0]     req_tdata  = '0;
   logic [0:0]                req_tuser  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_WIDTH-1:0]      rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   // handshake history seen by the drivers
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   stim_type   stim_q[$];
   totals_type due_totals[$];

   int beats_queued   = 0;
   int reports_queued = 0;
   int mismatch_count = 0;
   int stall_cycles   = 0;
   int quiet_cycles   = 0;
   int req_wait       = 0;
   int req_calm       = 0;
   int rsp_wait       = 0;
   int rsp_calm       = 0;
   int hold_seq       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;

   // predicted configuration and scanner
   logic                  utf8_on    = UTF8_MODE_RESET;
   logic [MASK_WIDTH-1:0] space_mask = MASK_RESET;
   logic                  in_word    = 1'b0;
   logic                  seq_open   = 1'b0;
   sub_type               seq_kind   = S_BAD;
   logic [CNT_W-1:0]      lines_seen = '0;
   logic [CNT_W-1:0]      words_seen = '0;
   logic [CNT_W-1:0]      chars_seen = '0;
   logic [CNT_W-1:0]      bytes_seen = '0;

   utf8_word_line_char_counter_unit #(.COUNT_WIDTH(CNT_W)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // saturating count
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   // advance the predicted scanner and counters by one data byte
   function automatic void scan_byte(input logic [7:0] b);
      scan_go_type go;
      sub_type     nxt;
      int          zw_bit;
      logic        blank;
      blank  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
      zw_bit = b[3:0] + 3;
      nxt    = S_BAD;
      go     = GO_OPEN;
      if (!utf8_on || !seq_open || b < 8'h80 || b >= 8'hC0) begin
         // byte taken as if nothing were pending
         if (b == 8'h0A) go = GO_NEWLINE;
         else if (blank) go = GO_BLANK;
         else if (!utf8_on || b < 8'h80) go = GO_GLYPH;
         else if (b == 8'hC2) nxt = S_DUO_C2;
         else if (b >= 8'hC3 && b <= 8'hDF) nxt = S_DUO_X;
         else if (b == 8'hE0) nxt = S_TRI_E0;
         else if (b == 8'hE1) nxt = S_TRI_E1;
         else if (b == 8'hE2) nxt = S_TRI_E2;
         else if (b == 8'hE3) nxt = S_TRI_E3;
         else if (b == 8'hED) nxt = S_TRI_ED;
         else if (b >= 8'hE4 && b <= 8'hEF) nxt = S_TRI_X;
         else if (b == 8'hF0) nxt = S_Q2_F0;
         else if (b >= 8'hF1 && b <= 8'hF3) nxt = S_Q2_X;
         else if (b == 8'hF4) nxt = S_Q2_F4;
      end else begin
         // continuation of the pending sequence
         case (seq_kind)
            S_DUO_C2: begin
               go = ((b == 8'h85 && space_mask[0]) || (b == 8'hA0 && space_mask[1])) ?
                    GO_BLANK : GO_GLYPH;
            end
            S_DUO_X, S_T3_X, S_Q4: go = GO_GLYPH;
            S_TRI_E0: nxt = (b < 8'hA0) ? S_BAD : S_T3_X;
            S_TRI_E1: nxt = (b == 8'h9A) ? S_T3_E1_9A : S_T3_X;
            S_TRI_E2: begin
               nxt = (b == 8'h80) ? S_T3_E2_80 : (b == 8'h81) ? S_T3_E2_81 : S_T3_X;
            end
            S_TRI_E3: nxt = (b == 8'h80) ? S_T3_E3_80 : S_T3_X;
            S_TRI_ED: nxt = (b >= 8'hA0) ? S_BAD : S_T3_X;
            S_TRI_X: nxt = S_T3_X;
            S_T3_E1_9A: go = (b == 8'h80 && space_mask[2]) ? GO_BLANK : GO_GLYPH;
            S_T3_E2_80: begin
               // u+2000..u+200b, line and paragraph separators, narrow nbsp
               go = ((b <= 8'h8B && space_mask[zw_bit]) ||
                     (b == 8'hA8 && space_mask[15]) || (b == 8'hA9 && space_mask[16]) ||
                     (b == 8'hAF && space_mask[17])) ? GO_BLANK : GO_GLYPH;
            end
            S_T3_E2_81: go = (b == 8'h9F && space_mask[18]) ? GO_BLANK : GO_GLYPH;
            S_T3_E3_80: go = (b == 8'h80 && space_mask[19]) ? GO_BLANK : GO_GLYPH;
            S_Q2_F0: nxt = (b < 8'h90) ? S_BAD : S_Q3;
            S_Q2_F4: nxt = (b >= 8'h90) ? S_BAD : S_Q3;
            S_Q2_X: nxt = S_Q3;
            S_Q3: nxt = S_Q4;
            default: nxt = S_BAD;
         endcase
      end
      bytes_seen = sat_inc(bytes_seen);
      if (go == GO_OPEN) begin
         seq_open = 1'b1;
         seq_kind = nxt;
      end else begin
         seq_open   = 1'b0;
         chars_seen = sat_inc(chars_seen);
         if (go == GO_NEWLINE) lines_seen = sat_inc(lines_seen);
         if (go == GO_GLYPH && !in_word) words_seen = sat_inc(words_seen);
         in_word = (go == GO_GLYPH);
      end
   endfunction

   task automatic note_miss(input string msg);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISSES) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_total(input string name, input logic [TOTAL_WIDTH-1:0] want,
                              input logic [TOTAL_WIDTH-1:0] got);
      if (got !== want) note_miss($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // stimulus queue helpers
   function automatic logic [7:0] rnd_byte(input logic [7:0] lo, input logic [7:0] hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic logic [7:0] tail_byte();
      return rnd_byte(8'h80, 8'hBF);
   endfunction

   function automatic logic [7:0] blank_byte();
      int k;
      k = $urandom_range(5, 0);
      return (k == 5) ? 8'h20 : 8'h09 + 8'(k);
   endfunction

   // mode word with noise in the unused upper bits
   function automatic logic [CSR_DATA_WIDTH-1:0] mode_word(input logic m);
      logic [CSR_DATA_WIDTH-1:0] w;
      w    = CSR_DATA_WIDTH'($urandom);
      w[0] = m;
      return w;
   endfunction

   task automatic push_beat(input logic op, input logic [7:0] b);
      stim_q.push_back('{kind: ACT_BEAT, op: op, data: b, addr: '0, wdata: '0});
      beats_queued++;
      if (op == OP_REPORT) reports_queued++;
   endtask

   task automatic push_data(input logic [7:0] b);
      push_beat(OP_DATA, b);
   endtask

   task automatic push_ctl(input act_type kind, input logic [CSR_ADDR_WIDTH-1:0] a,
                           input logic [CSR_DATA_WIDTH-1:0] v);
      stim_q.push_back('{kind: kind, op: OP_DATA, data: '0, addr: a, wdata: v});
   endtask

   // one random token: mostly well-formed text, some broken sequences and noise
   task automatic push_token();
      int         pick;
      int         tail;
      logic [7:0] lead;
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         push_beat(OP_REPORT, rnd_byte(8'h00, 8'hFF));
      end else if (pick < 28) begin
         push_data(rnd_byte(8'h21, 8'h7E));
      end else if (pick < 38) begin
         push_data(blank_byte());
      end else if (pick < 46) begin
         push_data(rnd_byte(8'hC2, 8'hDF));
         push_data(tail_byte());
      end else if (pick < 56) begin
         // unicode spaces and their close neighbors
         case ($urandom_range(6, 0))
            0: begin
               push_data(8'hC2);
               push_data($urandom_range(1, 0) ? 8'h85 : 8'hA0);
            end
            1: begin
               push_data(8'hE1); push_data(8'h9A); push_data(rnd_byte(8'h80, 8'h81));
            end
            2: begin
               push_data(8'hE2); push_data(8'h80); push_data(rnd_byte(8'h80, 8'h8C));
            end
            3: begin
               push_data(8'hE2); push_data(8'h80); push_data(rnd_byte(8'hA7, 8'hAF));
            end
            4: begin
               push_data(8'hE2); push_data(8'h81); push_data(rnd_byte(8'h9E, 8'h9F));
            end
            5: begin
               push_data(8'hE3); push_data(8'h80); push_data(rnd_byte(8'h80, 8'h81));
            end
            default: begin
               push_data(8'hE2); push_data(rnd_byte(8'h80, 8'h81)); push_data(tail_byte());
            end
         endcase
      end else if (pick < 66) begin
         // three-byte forms, sometimes overlong or surrogate
         lead = rnd_byte(8'hE0, 8'hEF);
         push_data(lead);
         if ($urandom_range(3, 0) == 0) push_data(tail_byte());
         else if (lead == 8'hE0) push_data(rnd_byte(8'hA0, 8'hBF));
         else if (lead == 8'hED) push_data(rnd_byte(8'h80, 8'h9F));
         else push_data(tail_byte());
         push_data(tail_byte());
      end else if (pick < 76) begin
         // four-byte forms, sometimes overlong or above u+10ffff
         lead = rnd_byte(8'hF0, 8'hF4);
         push_data(lead);
         if ($urandom_range(3, 0) == 0) push_data(tail_byte());
         else if (lead == 8'hF0) push_data(rnd_byte(8'h90, 8'hBF));
         else if (lead == 8'hF4) push_data(rnd_byte(8'h80, 8'h8F));
         else push_data(tail_byte());
         push_data(tail_byte());
         push_data(tail_byte());
      end else if (pick < 84) begin
         // sequence cut short by whatever follows
         push_data(rnd_byte(8'hC2, 8'hF4));
         tail = $urandom_range(2, 0);
         repeat (tail) push_data(tail_byte());
      end else if (pick < 92) begin
         push_data(rnd_byte(8'h00, 8'hFF));
      end else begin
         // bytes that never start a character
         case ($urandom_range(2, 0))
            0: push_data(tail_byte());
            1: push_data(rnd_byte(8'hC0, 8'hC1));
            default: push_data(rnd_byte(8'hF5, 8'hFF));
         endcase
      end
   endtask

   // sampling: predictor, result check, watchdog
   always @(posedge clock) begin : watch_proc
      totals_type got;
      totals_type want;
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         rsp_fired <= rsp_tvalid && rsp_tready;
         // result beat against the oldest report
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_totals.size() == 0) begin
               note_miss("result beat with no report outstanding");
            end else begin
               want = due_totals.pop_front();
               check_total("line_total", want.line_total, got.line_total);
               check_total("word_total", want.word_total, got.word_total);
               check_total("char_total", want.char_total, got.char_total);
               check_total("byte_total", want.byte_total, got.byte_total);
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_addr)
               REG_UTF8_MODE: utf8_on = csr_wdata[0];
               REG_SPACE_MASK: space_mask = csr_wdata[MASK_WIDTH-1:0];
               default: ;
            endcase
         end
         // accepted input beat
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_REPORT) begin
               due_totals.push_back('{byte_total: bytes_seen[TOTAL_WIDTH-1:0],
                                      char_total: chars_seen[TOTAL_WIDTH-1:0],
                                      word_total: words_seen[TOTAL_WIDTH-1:0],
                                      line_total: lines_seen[TOTAL_WIDTH-1:0]});
               in_word    = 1'b0;
               seq_open   = 1'b0;
               lines_seen = '0;
               words_seen = '0;
               chars_seen = '0;
               bytes_seen = '0;
            end else begin
               scan_byte(req_tdata);
            end
         end
         // idle tracking for register writes and the watchdog
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || due_totals.size() != 0)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // input side: beats, register writes, pauses
   always @(negedge clock) begin : drive_proc
      logic     send;
      logic     wr;
      logic     settled;
      stim_type act;
      if (!reset) begin
         send    = req_tvalid && !req_fired;
         wr      = 1'b0;
         settled = (due_totals.size() == 0) && (quiet_cycles >= SETTLE_CYCLES);
         if (!send) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (stim_q.size() != 0) begin
               act = stim_q[0];
               case (act.kind)
                  ACT_BEAT: begin
                     req_tdata <= act.data;
                     req_tuser <= act.op;
                     send = 1'b1;
                     void'(stim_q.pop_front());
                     // gap after this beat, with occasional runs of no gaps
                     if (req_calm > 0) req_calm--;
                     else if ($urandom_range(24, 0) == 0) req_calm = $urandom_range(40, 15);
                     req_wait = (req_calm > 0) ? 0 : $urandom_range(MAX_WAIT, 0);
                  end
                  ACT_CSR: begin
                     if (settled) begin
                        csr_addr  <= act.addr;
                        csr_wdata <= act.wdata;
                        wr = 1'b1;
                        void'(stim_q.pop_front());
                     end
                  end
                  ACT_DRAIN: begin
                     if (settled) void'(stim_q.pop_front());
                  end
                  default: begin
                     hold_seq <= hold_seq + 1;
                     void'(stim_q.pop_front());
                  end
               endcase
            end
         end
         req_tvalid <= send;
         csr_we     <= wr;
      end
   end

   // result side: random back-pressure and the long hold-off
   always @(negedge clock) begin : accept_proc
      if (!reset) begin
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_fired) begin
            if (rsp_calm > 0) rsp_calm--;
            else if ($urandom_range(24, 0) == 0) rsp_calm = $urandom_range(40, 15);
            rsp_wait = (rsp_calm > 0) ? 0 : $urandom_range(MAX_WAIT, 0);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin : stim_proc
      int                    ph;
      int                    phase_end;
      logic                  mode_sel;
      logic [MASK_WIDTH-1:0] mask_sel;

      // byte mode: ascii extremes, blanks, high bytes
      push_ctl(ACT_CSR, REG_UTF8_MODE, mode_word(1'b0));
      push_ctl(ACT_CSR, REG_SPACE_MASK, MASK_RESET);
      push_data(8'h61); push_data(8'h20); push_data(8'h0A); push_data(8'h00);
      push_data(8'hFF); push_data(8'h80); push_beat(OP_REPORT, 8'hFF);

      // utf-8 with every space enabled: nel, overlong, stray, cut-off, emoji,
      // surrogate, above u+10ffff
      push_ctl(ACT_CSR, REG_UTF8_MODE, mode_word(1'b1));
      push_ctl(ACT_CSR, REG_SPACE_MASK, '1);
      push_data(8'hC2); push_data(8'h85); push_data(8'h77);
      push_data(8'hE0); push_data(8'h80); push_data(8'h80);
      push_data(8'hE2); push_data(8'h41);
      push_data(8'hF0); push_data(8'h9F); push_data(8'h98); push_data(8'h80);
      push_data(8'hED); push_data(8'hA0); push_data(8'hF4); push_data(8'h90);
      push_beat(OP_REPORT, 8'h00);

      // switch to byte mode while a sequence is pending
      push_data(8'hE2);
      push_ctl(ACT_CSR, REG_UTF8_MODE, mode_word(1'b0));
      push_data(8'h80);
      push_beat(OP_REPORT, 8'h5A);

      // random phases under rotating settings
      ph = 0;
      while (beats_queued < ITEM_TARGET || reports_queued < REPORT_TARGET) begin
         case (ph % 6)
            0: begin mode_sel = 1'b1; mask_sel = '0; end
            1: begin mode_sel = 1'b1; mask_sel = '1; end
            3: begin mode_sel = 1'b0; mask_sel = MASK_WIDTH'($urandom); end
            4: begin mode_sel = 1'b1; mask_sel = MASK_RESET; end
            default: begin mode_sel = 1'b1; mask_sel = MASK_WIDTH'($urandom); end
         endcase
         push_ctl(ACT_CSR, REG_UTF8_MODE, mode_word(mode_sel));
         push_ctl(ACT_CSR, REG_SPACE_MASK, mask_sel);
         if (ph == 2) begin
            // receiver holds off while reports pile up, then the sender waits
            push_ctl(ACT_HOLD, '0, '0);
            repeat (5) begin
               push_data(rnd_byte(8'h21, 8'h7E));
               push_beat(OP_REPORT, rnd_byte(8'h00, 8'hFF));
            end
            push_ctl(ACT_DRAIN, '0, '0);
         end
         phase_end = beats_queued + $urandom_range(110, 70);
         while (beats_queued < phase_end) push_token();
         ph++;
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_tvalid) @(posedge clock);
      while (due_totals.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
